@@ rtl/lkvt_pkg.sv @@
// lkvt_pkg: shared types and codes for the linear key-value table.
// Used by the channel interfaces, the controller, the datapath and the checker.
// No dependencies.
`timescale 1ns / 1ps

package lkvt_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned CommandBits = 2;
  localparam int unsigned KeyInBits   = 32;
  localparam int unsigned ValueIoBits = 64;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned CountOutBits = 5;

  // Command codes
  localparam logic [CommandBits-1:0] CMD_ADD    = 2'd0;
  localparam logic [CommandBits-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CommandBits-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CommandBits-1:0] CMD_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [StatusBits-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_FULL      = 2'd2;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;  // latch the incoming item and its match vector
    logic exec;     // apply the operation and load the result register
  } lkvt_ctl_t;

endpackage

@@ rtl/lkvt_if.sv @@
// lkvt_in_if / lkvt_out_if: valid/ready channels for table commands and results.
// Depends on lkvt_pkg for the field widths.
`timescale 1ns / 1ps

interface lkvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [lkvt_pkg::CommandBits-1:0]    command;
  logic [lkvt_pkg::KeyInBits-1:0]      key;
  logic signed [lkvt_pkg::ValueIoBits-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lkvt_out_if;
  logic                                valid;
  logic                                ready;
  logic [lkvt_pkg::StatusBits-1:0]     status;
  logic                                found;
  logic signed [lkvt_pkg::ValueIoBits-1:0] read_value;
  logic [lkvt_pkg::CountOutBits-1:0]   entry_count;

  modport source (output valid, output status, output found, output read_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input entry_count, output ready);
endinterface

@@ rtl/lkvt_ctrl.sv @@
// lkvt_ctrl: two-state sequencer for the key-value table plus the result valid flag.
// Depends on lkvt_pkg (lkvt_ctl_t).
`timescale 1ns / 1ps

module lkvt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lkvt_pkg::lkvt_ctl_t ctl_o
);
  import lkvt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic capture, exec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign capture    = in_valid_i & in_ready_o;
  // result register must be empty or draining before it is overwritten
  assign exec       = (state_q == ST_EXEC) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ctl_o.capture = capture;
  assign ctl_o.exec    = exec;

endmodule

@@ rtl/lkvt_datapath.sv @@
// lkvt_datapath: row of key/value cells with per-cell match, one-step compaction
// shift on remove, entry count and the result register. Depends on lkvt_pkg.
`timescale 1ns / 1ps

module lkvt_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lkvt_pkg::lkvt_ctl_t                    ctl_i,
  input  logic [lkvt_pkg::CommandBits-1:0]       command_i,
  input  logic [lkvt_pkg::KeyInBits-1:0]         key_i,
  input  logic signed [lkvt_pkg::ValueIoBits-1:0] value_i,
  output logic [lkvt_pkg::StatusBits-1:0]        status_o,
  output logic                                   found_o,
  output logic signed [lkvt_pkg::ValueIoBits-1:0] read_value_o,
  output logic [lkvt_pkg::CountOutBits-1:0]      entry_count_o
);
  import lkvt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  // cell storage
  logic [KEY_BITS-1:0]   key_r [DEPTH];
  logic [VALUE_BITS-1:0] val_r [DEPTH];
  logic [KEY_BITS-1:0]   nxt_key [DEPTH];
  logic [VALUE_BITS-1:0] nxt_val [DEPTH];

  logic [CW-1:0] count_q, count_d;

  // latched item
  logic [CommandBits-1:0] cmd_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [VALUE_BITS-1:0]  value_q;
  logic [DEPTH-1:0]       hit_q, hit_d;

  logic [KEY_BITS-1:0] key_in;
  logic                found, full;
  logic [IW-1:0]       slot;
  logic [VALUE_BITS-1:0] sel_val;

  logic [StatusBits-1:0]       status_d;
  logic                        found_d;
  logic signed [ValueIoBits-1:0] read_value_d;

  assign key_in = KEY_BITS'(key_i);

  // parallel match against live cells; keys in the table are unique, so onehot0
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_d[i] = (CW'(i) < count_q) && (key_r[i] == key_in);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= command_i;
      key_q   <= key_in;
      value_q <= VALUE_BITS'(value_i);
      hit_q   <= hit_d;
    end
  end

  assign found = |hit_q;
  assign full  = (count_q == CW'(DEPTH));

  always_comb begin
    slot    = '0;
    sel_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot    = slot | ({IW{hit_q[i]}} & IW'(i));
      sel_val = sel_val | ({VALUE_BITS{hit_q[i]}} & val_r[i]);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_mid
      assign nxt_key[g] = key_r[g+1];
      assign nxt_val[g] = val_r[g+1];
    end else begin : g_last
      assign nxt_key[g] = key_r[g];
      assign nxt_val[g] = val_r[g];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.exec) begin
        case (cmd_q)
          CMD_ADD: begin
            if (found) begin
              if (hit_q[g]) val_r[g] <= value_q;
            end else if (!full && (CW'(g) == count_q)) begin
              key_r[g] <= key_q;
              val_r[g] <= value_q;
            end
          end
          CMD_REMOVE: begin
            // everything from the removed slot upward moves down one place
            if (found && (IW'(g) >= slot)) begin
              key_r[g] <= nxt_key[g];
              val_r[g] <= nxt_val[g];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    status_d     = STATUS_OK;
    found_d      = found;
    read_value_d = '0;
    case (cmd_q)
      CMD_ADD: begin
        if (!found) begin
          if (full) status_d = STATUS_FULL;
          else      count_d  = count_q + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) count_d  = count_q - CW'(1);
        else       status_d = STATUS_NOT_FOUND;
      end
      CMD_LOOKUP: begin
        if (found) read_value_d = ValueIoBits'($signed(sel_val));
        else       status_d     = STATUS_NOT_FOUND;
      end
      CMD_CLEAR: begin
        count_d = '0;
        found_d = 1'b0;
      end
      default: begin
        count_d = '0;
        found_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      status_o      <= status_d;
      found_o       <= found_d;
      read_value_o  <= read_value_d;
      entry_count_o <= CountOutBits'(count_d);
    end
  end

endmodule

@@ rtl/linear_key_value_table.sv @@
// linear_key_value_table: top level, joins the sequencer and the cell datapath.
// Depends on lkvt_pkg, lkvt_in_if, lkvt_out_if, lkvt_ctrl and lkvt_datapath.
//
// Fixed-capacity key/value table held in DEPTH register cells, packed in insertion
// order. Each command first latches the item and compares its key against every
// live cell at once, then applies the add, remove (with a shift of the later
// cells), lookup or clear and loads the result register. A new command is not
// taken until the previous one has been applied; the input waits longer while the
// previous result is still held by the consumer, as the apply step then stalls.
// No clearing pass is needed after reset. entry_count reports the count modulo 32.
`timescale 1ns / 1ps

module linear_key_value_table #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkvt_in_if.sink    cmd_i,
  lkvt_out_if.source rsp_o
);
  import lkvt_pkg::*;

  lkvt_ctl_t ctl;

  lkvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctl_o       (ctl)
  );

  lkvt_datapath #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .command_i     (cmd_i.command),
    .key_i         (cmd_i.key),
    .value_i       (cmd_i.value),
    .status_o      (rsp_o.status),
    .found_o       (rsp_o.found),
    .read_value_o  (rsp_o.read_value),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule

@@ rtl/lkvt_checker.sv @@
// lkvt_checker: port-level assertions for linear_key_value_table, bound to the top.
// Depends on lkvt_pkg for status codes.
`timescale 1ns / 1ps

module lkvt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [lkvt_pkg::StatusBits-1:0]    status_i,
  input logic                               found_i,
  input logic [lkvt_pkg::ValueIoBits-1:0]   read_value_i,
  input logic [lkvt_pkg::CountOutBits-1:0]  entry_count_i
);
  import lkvt_pkg::*;

  // a held result does not change until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(found_i)
      && $stable(read_value_i) && $stable(entry_count_i))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while previous item in work");

  // failed operations report no hit and no data
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != STATUS_OK) |-> !found_i && (read_value_i == '0))
    else $error("failed operation reports a hit or data");

  // data is only returned on a hit
  a_data_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (read_value_i != '0) |-> found_i)
    else $error("read value without hit");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == STATUS_OK) || (status_i == STATUS_NOT_FOUND)
      || (status_i == STATUS_FULL))
    else $error("undefined status code");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .found_i       (rsp_o.found),
  .read_value_i  (rsp_o.read_value),
  .entry_count_i (rsp_o.entry_count)
);

@@ tb/linear_key_value_table_tb.sv @@
// linear_key_value_table_tb: self-checking bench for the linear key-value table.
// Depends on lkvt_pkg, lkvt_in_if, lkvt_out_if and linear_key_value_table.
// A directed table runs first, then random commands under four idle/stall phases.
`timescale 1ns / 1ps

module linear_key_value_table_tb;
  import lkvt_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned KeyPoolSize = 24;  // more keys than slots, so the table fills
  localparam int unsigned ItemsPerPhase = 112;
  localparam int unsigned IdleLimit = 2000;
  localparam logic [ValueIoBits-1:0] MinValue = 64'h8000_0000_0000_0000;
  localparam logic [ValueIoBits-1:0] MaxValue = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueIoBits-1:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [StatusBits-1:0]   status;
    logic                    found;
    logic [ValueIoBits-1:0]  read_value;
    logic [CountOutBits-1:0] entry_count;
  } table_result_t;

  typedef struct packed {
    logic [CommandBits-1:0] command;
    logic [KeyInBits-1:0]   key;
    logic [ValueIoBits-1:0] value;
    logic                   typed;  // expectation given in the row
    table_result_t          result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lkvt_in_if  cmd_ch ();
  lkvt_out_if rsp_ch ();

  linear_key_value_table #(
    .DEPTH     (TableDepth),
    .KEY_BITS  (KeyInBits),
    .VALUE_BITS(ValueIoBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table
  logic [KeyInBits-1:0]   shadow_keys   [TableDepth];
  logic [ValueIoBits-1:0] shadow_values [TableDepth];
  int                     shadow_count = 0;

  table_result_t pending_results [$];
  table_result_t oldest_result;
  logic [KeyInBits-1:0] key_pool [KeyPoolSize];
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned idle_cycles = 0;
  int errors = 0;

  function automatic table_result_t apply_table_op(input logic [CommandBits-1:0] cmd,
                                                   input logic [KeyInBits-1:0] key,
                                                   input logic [ValueIoBits-1:0] value);
    table_result_t res;
    int slot;
    res = '0;
    res.status = STATUS_OK;
    slot = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    case (cmd)
      CMD_ADD: begin
        if (slot >= 0) begin
          res.found = 1'b1;
          shadow_values[slot] = value;
        end else if (shadow_count >= TableDepth) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_values[shadow_count] = value;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (slot >= 0) begin
          res.found = 1'b1;
          // close the gap: later entries move down one slot
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
          end
          shadow_count--;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        if (slot >= 0) begin
          res.found = 1'b1;
          res.read_value = shadow_values[slot];
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: shadow_count = 0;
    endcase
    res.entry_count = CountOutBits'(shadow_count);
    return res;
  endfunction

  function automatic stim_row_t table_row(input logic [CommandBits-1:0] cmd,
                                          input logic [KeyInBits-1:0] key,
                                          input logic [ValueIoBits-1:0] value,
                                          input logic typed,
                                          input logic [StatusBits-1:0] status,
                                          input logic found,
                                          input logic [ValueIoBits-1:0] read_value,
                                          input logic [CountOutBits-1:0] entry_count);
    stim_row_t row;
    row.command = cmd;
    row.key = key;
    row.value = value;
    row.typed = typed;
    row.result.status = status;
    row.result.found = found;
    row.result.read_value = read_value;
    row.result.entry_count = entry_count;
    return row;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Drive one item, wait for its handshake and queue what it should return.
  task automatic send_item(input stim_row_t row);
    table_result_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= row.command;
    cmd_ch.key     <= row.key;
    cmd_ch.value   <= row.value;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predicted = apply_table_op(row.command, row.key, row.value);
    pending_results.push_back(row.typed ? row.result : predicted);
  endtask

  // Sender pauses until every outstanding result has drained.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item pending: status %0d found %0d value %0h count %0d",
                 $time, rsp_ch.status, rsp_ch.found, rsp_ch.read_value, rsp_ch.entry_count);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", 64'(oldest_result.status), 64'(rsp_ch.status));
        check_field("found", 64'(oldest_result.found), 64'(rsp_ch.found));
        check_field("read_value", oldest_result.read_value, rsp_ch.read_value);
        check_field("entry_count", 64'(oldest_result.entry_count), 64'(rsp_ch.entry_count));
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("linear_key_value_table_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    stim_row_t row;
    int unsigned pick;

    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_LOOKUP;
    cmd_ch.key     = '0;
    cmd_ch.value   = '0;
    rsp_ch.ready   = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KeyPoolSize; i++) key_pool[i] = $urandom;

    // Directed table; rows with typed=0 are checked by the shadow model
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'h0, AllOnes, 1'b1,
                                      STATUS_NOT_FOUND, 1'b0, 64'd0, 5'd0));
    directed_rows.push_back(table_row(CMD_ADD, 32'h0, MinValue, 1'b1,
                                      STATUS_OK, 1'b0, 64'd0, 5'd1));
    directed_rows.push_back(table_row(CMD_ADD, 32'hFFFF_FFFF, MaxValue, 1'b1,
                                      STATUS_OK, 1'b0, 64'd0, 5'd2));
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'h0, 64'd0, 1'b1,
                                      STATUS_OK, 1'b1, MinValue, 5'd2));
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'hFFFF_FFFF, 64'd0, 1'b1,
                                      STATUS_OK, 1'b1, MaxValue, 5'd2));
    // update in place
    directed_rows.push_back(table_row(CMD_ADD, 32'h0, AllOnes, 1'b1,
                                      STATUS_OK, 1'b1, 64'd0, 5'd2));
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'h0, MaxValue, 1'b1,
                                      STATUS_OK, 1'b1, AllOnes, 5'd2));
    directed_rows.push_back(table_row(CMD_REMOVE, 32'h1234_5678, 64'd0, 1'b1,
                                      STATUS_NOT_FOUND, 1'b0, 64'd0, 5'd2));
    for (int i = 0; i < TableDepth - 2; i++) begin
      directed_rows.push_back(table_row(CMD_ADD, 32'h100 + i, {$urandom, $urandom}, 1'b0,
                                        STATUS_OK, 1'b0, 64'd0, 5'd0));
    end
    // table now full
    directed_rows.push_back(table_row(CMD_ADD, 32'hAAAA_5555, MaxValue, 1'b1,
                                      STATUS_FULL, 1'b0, 64'd0, 5'd16));
    directed_rows.push_back(table_row(CMD_ADD, 32'hFFFF_FFFF, 64'd0, 1'b1,
                                      STATUS_OK, 1'b1, 64'd0, 5'd16));
    // removing slot 0 shifts every later entry
    directed_rows.push_back(table_row(CMD_REMOVE, 32'h0, MinValue, 1'b1,
                                      STATUS_OK, 1'b1, 64'd0, 5'd15));
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'h10D, 64'd0, 1'b0,
                                      STATUS_OK, 1'b0, 64'd0, 5'd0));
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'hFFFF_FFFF, 64'd0, 1'b0,
                                      STATUS_OK, 1'b0, 64'd0, 5'd0));
    directed_rows.push_back(table_row(CMD_CLEAR, 32'h5555_AAAA, AllOnes, 1'b1,
                                      STATUS_OK, 1'b0, 64'd0, 5'd0));
    // stale store contents must not match after clear
    directed_rows.push_back(table_row(CMD_LOOKUP, 32'hFFFF_FFFF, 64'd0, 1'b1,
                                      STATUS_NOT_FOUND, 1'b0, 64'd0, 5'd0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pick = $urandom_range(99);
        if (pick < 45)      row.command = CMD_ADD;
        else if (pick < 65) row.command = CMD_REMOVE;
        else if (pick < 96) row.command = CMD_LOOKUP;
        else                row.command = CMD_CLEAR;
        row.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KeyPoolSize - 1)]
                                            : $urandom;
        row.value = {$urandom, $urandom};
        row.typed = 1'b0;
        row.result = '0;
        send_item(row);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("linear_key_value_table_tb passed");
    end else begin
      $display("linear_key_value_table_tb failed");
    end
    $finish;
  end

endmodule

@@ linear_key_value_table.f @@
rtl/lkvt_pkg.sv
rtl/lkvt_if.sv
rtl/lkvt_ctrl.sv
rtl/lkvt_datapath.sv
rtl/linear_key_value_table.sv
rtl/lkvt_checker.sv
tb/linear_key_value_table_tb.sv
